>>> rtl/core/hqn_pkg.sv
// ----------------------------------------------------------------------------
// hqn_pkg
// Shared types and constants for the heightfield quad and normal generator.
// ----------------------------------------------------------------------------
package hqn_pkg;

  localparam int MAX_SIDE_DEF = 128;

  localparam logic [14:0] ONE_Q14 = 15'd16384;
  localparam logic [15:0] ONE_Q88 = 16'd256;
  localparam logic [33:0] ONE_Q88_SQ = 34'd65536;

  // neighbour selects for height reads
  localparam logic [2:0] SEL_C = 3'd0;
  localparam logic [2:0] SEL_L = 3'd1;
  localparam logic [2:0] SEL_R = 3'd2;
  localparam logic [2:0] SEL_U = 3'd3;
  localparam logic [2:0] SEL_D = 3'd4;

  // normal components
  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  // configuration register indexes
  localparam logic [7:0] REG_WIDTH  = 8'd0;
  localparam logic [7:0] REG_LENGTH = 8'd1;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_GEN  = 1'b1;

  typedef enum logic [3:0] {
    OP_NOP, OP_READ, OP_CAP, OP_SQX, OP_SQZ, OP_SUM, OP_MAG,
    OP_TSQ, OP_PLO, OP_PHI, OP_CMP, OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic              mode;
    logic [6:0]        col;
    logic [6:0]        row;
    logic signed [15:0] height;
  } hqn_in_t;

  typedef struct packed {
    logic signed [7:0]  pos_x;
    logic signed [15:0] pos_y;
    logic signed [7:0]  pos_z;
    logic signed [15:0] norm_x;
    logic [14:0]        norm_y;
    logic signed [15:0] norm_z;
    logic               last;
  } hqn_out_t;

  typedef struct packed {
    dp_op_t     op;
    logic       take;
    logic [1:0] k;
    logic [2:0] sel;
    logic [1:0] comp;
    logic [3:0] bitpos;
  } hqn_cmd_t;

  typedef struct packed {
    logic cell_ok;
    logic border;
    logic out_free;
  } hqn_sts_t;

endpackage

>>> rtl/core/hqn_ctrl.sv
// ----------------------------------------------------------------------------
// hqn_ctrl
// Sequencer: steps the datapath through reads, squares and the bit-serial
// rounding search for each vertex.
// ----------------------------------------------------------------------------
module hqn_ctrl import hqn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_mode,
  output logic     in_stall,
  input  hqn_sts_t sts,
  output hqn_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_CAP, S_SQX, S_SQZ, S_SUM, S_MAG,
    S_TSQ, S_PLO, S_PHI, S_CMP, S_OUT
  } state_t;

  state_t     state_r;
  logic [1:0] k_r;
  logic [2:0] sel_r;
  logic [1:0] comp_r;
  logic [3:0] bit_r;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd.take   = (state_r == S_IDLE) && in_valid;
    cmd.k      = k_r;
    cmd.sel    = sel_r;
    cmd.comp   = comp_r;
    cmd.bitpos = bit_r;
    case (state_r)
      S_READ:  cmd.op = OP_READ;
      S_CAP:   cmd.op = OP_CAP;
      S_SQX:   cmd.op = OP_SQX;
      S_SQZ:   cmd.op = OP_SQZ;
      S_SUM:   cmd.op = OP_SUM;
      S_MAG:   cmd.op = OP_MAG;
      S_TSQ:   cmd.op = OP_TSQ;
      S_PLO:   cmd.op = OP_PLO;
      S_PHI:   cmd.op = OP_PHI;
      S_CMP:   cmd.op = OP_CMP;
      S_OUT:   cmd.op = OP_OUT;
      default: cmd.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      sel_r   <= '0;
      comp_r  <= '0;
      bit_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_mode == MODE_GEN && sts.cell_ok) begin
            k_r     <= '0;
            sel_r   <= SEL_C;
            state_r <= S_READ;
          end
        end
        S_READ: state_r <= S_CAP;
        S_CAP: begin
          if (sts.border) begin
            state_r <= S_OUT;
          end else if (sel_r == SEL_D) begin
            state_r <= S_SQX;
          end else begin
            sel_r   <= sel_r + 3'd1;
            state_r <= S_READ;
          end
        end
        S_SQX: state_r <= S_SQZ;
        S_SQZ: state_r <= S_SUM;
        S_SUM: begin
          comp_r  <= COMP_X;
          state_r <= S_MAG;
        end
        S_MAG: begin
          bit_r   <= 4'd14;
          state_r <= S_TSQ;
        end
        S_TSQ: state_r <= S_PLO;
        S_PLO: state_r <= S_PHI;
        S_PHI: state_r <= S_CMP;
        S_CMP: begin
          if (bit_r != 4'd0) begin
            bit_r   <= bit_r - 4'd1;
            state_r <= S_TSQ;
          end else if (comp_r == COMP_Z) begin
            state_r <= S_OUT;
          end else begin
            comp_r  <= comp_r + 2'd1;
            state_r <= S_MAG;
          end
        end
        S_OUT: begin
          if (sts.out_free) begin
            if (k_r == 2'd3) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r + 2'd1;
              sel_r   <= SEL_C;
              state_r <= S_READ;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/hqn_dp.sv
// ----------------------------------------------------------------------------
// hqn_dp
// Datapath: height store, configuration registers, neighbour heights,
// squaring and rounding search, output register.
// ----------------------------------------------------------------------------
module hqn_dp import hqn_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  hqn_in_t    in_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  hqn_cmd_t   cmd,
  output hqn_sts_t   sts,
  input  logic       out_stall,
  output logic       out_valid,
  output hqn_out_t   out_data
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_r;

  logic [7:0] width_r, length_r;
  logic [7:0] w_use, l_use;

  logic [6:0] x_r, z_r;
  logic       border_r;
  logic [15:0] h_r [5];

  logic        dxneg_r, dzneg_r;
  logic [15:0] mx_r, mz_r;
  logic [31:0] mx2_r, mz2_r;
  logic [33:0] s_r;
  logic [31:0] lim_r;
  logic [14:0] r_r;
  logic [31:0] t2_r;
  logic [48:0] plo_r, phi_r;
  logic [15:0] nx_r, nz_r;
  logic [14:0] ny_r;

  logic       out_valid_r;
  hqn_out_t   out_r;

  // in-use sizes, saturated to 2..MAX_SIDE
  function automatic logic [7:0] sat_side(input logic [7:0] v);
    logic [7:0] res;
    if (v < 8'd2) res = 8'd2;
    else if (int'(v) > MAX_SIDE) res = 8'(MAX_SIDE);
    else res = v;
    return res;
  endfunction

  assign w_use = sat_side(width_r);
  assign l_use = sat_side(length_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 8'd128;
      length_r <= 8'd128;
    end else if (cfg_we) begin
      if (cfg_index == REG_WIDTH)  width_r  <= cfg_data;
      if (cfg_index == REG_LENGTH) length_r <= cfg_data;
    end
  end

  // cell checks on the incoming beat
  logic [8:0] col9, row9;
  assign col9 = {2'b0, in_data.col};
  assign row9 = {2'b0, in_data.row};

  assign sts.cell_ok  = (col9 + 9'd1 < {1'b0, w_use}) && (row9 + 9'd1 < {1'b0, l_use});
  assign sts.border   = border_r;
  assign sts.out_free = !out_valid_r || !out_stall;

  logic border_in;
  assign border_in = (in_data.col == 7'd0) || (col9 == {1'b0, w_use} - 9'd2) ||
                     (in_data.row == 7'd0) || (row9 == {1'b0, l_use} - 9'd2);

  logic load_ok;
  assign load_ok = cmd.take && (in_data.mode == MODE_LOAD) &&
                   (int'(in_data.col) < MAX_SIDE) && (int'(in_data.row) < MAX_SIDE);

  // vertex and neighbour coordinates
  logic [7:0] vx, vz, ax, az;
  assign vx = {1'b0, x_r} + {7'b0, (cmd.k == 2'd0) || (cmd.k == 2'd3)};
  assign vz = {1'b0, z_r} + {7'b0, cmd.k[1]};

  always_comb begin
    ax = vx;
    az = vz;
    case (cmd.sel)
      SEL_L:   ax = vx - 8'd1;
      SEL_R:   ax = vx + 8'd1;
      SEL_U:   az = vz - 8'd1;
      SEL_D:   az = vz + 8'd1;
      default: begin
        ax = vx;
        az = vz;
      end
    endcase
  end

  logic [AW-1:0] waddr, raddr;
  assign waddr = AW'(int'(in_data.row) * MAX_SIDE + int'(in_data.col));
  assign raddr = AW'(int'(az) * MAX_SIDE + int'(ax));

  always_ff @(posedge clk) begin
    if (load_ok) mem[waddr] <= in_data.height;
    rdata_r <= mem[raddr];
  end

  // differences
  logic signed [16:0] dx, dz;
  assign dx = $signed({h_r[SEL_L][15], h_r[SEL_L]}) - $signed({h_r[SEL_R][15], h_r[SEL_R]});
  assign dz = $signed({h_r[SEL_U][15], h_r[SEL_U]}) - $signed({h_r[SEL_D][15], h_r[SEL_D]});

  logic [16:0] dx_abs, dz_abs;
  assign dx_abs = dx[16] ? 17'(-dx) : 17'(dx);
  assign dz_abs = dz[16] ? 17'(-dz) : 17'(dz);

  logic [15:0] mag;
  always_comb begin
    case (cmd.comp)
      COMP_X:  mag = mx_r;
      COMP_Y:  mag = ONE_Q88;
      default: mag = mz_r;
    endcase
  end

  // rounding search: largest r with (2r-1)^2 * S <= 4 * (mag*2^14)^2
  logic [14:0] cand;
  logic [15:0] tval;
  logic [65:0] prod, lim66;
  logic        fits;
  logic [14:0] r_new;
  assign cand  = r_r | (15'd1 << cmd.bitpos);
  assign tval  = {cand, 1'b0} - 16'd1;
  assign prod  = {phi_r, 17'b0} + {17'b0, plo_r};
  assign lim66 = {4'b0, lim_r, 30'b0};
  assign fits  = (prod <= lim66);
  assign r_new = fits ? cand : r_r;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      x_r      <= in_data.col;
      z_r      <= in_data.row;
      border_r <= border_in;
    end
    case (cmd.op)
      OP_CAP: h_r[cmd.sel] <= rdata_r;
      OP_SQX: begin
        dxneg_r <= dx[16];
        mx_r    <= dx_abs[15:0];
        mx2_r   <= dx_abs[15:0] * dx_abs[15:0];
      end
      OP_SQZ: begin
        dzneg_r <= dz[16];
        mz_r    <= dz_abs[15:0];
        mz2_r   <= dz_abs[15:0] * dz_abs[15:0];
      end
      OP_SUM: s_r <= {2'b0, mx2_r} + {2'b0, mz2_r} + ONE_Q88_SQ;
      OP_MAG: begin
        lim_r <= mag * mag;
        r_r   <= '0;
      end
      OP_TSQ: t2_r  <= tval * tval;
      OP_PLO: plo_r <= t2_r * s_r[16:0];
      OP_PHI: phi_r <= t2_r * s_r[33:17];
      OP_CMP: begin
        r_r <= r_new;
        if (cmd.bitpos == 4'd0) begin
          case (cmd.comp)
            COMP_X:  nx_r <= dxneg_r ? 16'(-{1'b0, r_new}) : {1'b0, r_new};
            COMP_Y:  ny_r <= r_new;
            default: nz_r <= dzneg_r ? 16'(-{1'b0, r_new}) : {1'b0, r_new};
          endcase
        end
      end
      default: ;
    endcase
  end

  // output register
  hqn_out_t out_nxt;
  always_comb begin
    out_nxt.pos_x  = 8'({1'b0, vx} - {2'b0, w_use[7:1]});
    out_nxt.pos_y  = h_r[SEL_C];
    out_nxt.pos_z  = 8'({1'b0, vz} - {2'b0, l_use[7:1]});
    out_nxt.norm_x = border_r ? 16'd0 : nx_r;
    out_nxt.norm_y = border_r ? ONE_Q14 : ny_r;
    out_nxt.norm_z = border_r ? 16'd0 : nz_r;
    out_nxt.last   = (cmd.k == 2'd3);
  end

  logic load_out;
  assign load_out = (cmd.op == OP_OUT) && sts.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (load_out) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/core/heightfield_quad_normal_gen.sv
// ----------------------------------------------------------------------------
// heightfield_quad_normal_gen
// Height store loader and per-cell quad generator with unit normals.
//
//   channel | direction | handshake        | beat carries
//   --------+-----------+------------------+-------------------------------
//   in_     | in        | valid / stall    | mode, col, row, height
//   out_    | out       | valid / stall    | one vertex: pos, normal, last
//   cfg_    | in        | valid / ready    | register index, data
//
// A load beat does not hold the input: the sample is written to the height
// store at acceptance. A generate beat for a border cell holds the input
// through a store read, capture and output per vertex; an interior cell also
// holds it through the bit-serial rounding search. Per vertex: five reads
// through the store's one read port, each a read step and a capture step,
// steps for the squared differences and their sum, then per normal component
// one setup step and 15 steps (square, two partial products, compare), three
// components, and one output step. A cell out of range is accepted and gives
// no vertex. Reset (rst_n, synchronous) clears control and the size registers
// only; the store itself is not cleared. A stalled output holds its vertex in
// the output register while the block carries on until it needs that
// register, and then waits in its output step until the output is free.
// ----------------------------------------------------------------------------
module heightfield_quad_normal_gen import hqn_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  hqn_in_t    in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output hqn_out_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  hqn_cmd_t cmd;
  hqn_sts_t sts;

  // configuration is always accepted; writes beyond the list are dropped
  assign cfg_ready = 1'b1;

  hqn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hqn_dp #(.MAX_SIDE(MAX_SIDE)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the heightfield quad and normal generator: loads
// height samples, asks for cell quads over several grid sizes and compares
// every vertex beat with an in-bench prediction of positions and normals.
// ----------------------------------------------------------------------------
module tb;
  import hqn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SIDE       = MAX_SIDE_DEF;
  localparam logic [7:0]  REG_SPARE  = 8'd2;   // index past the register list
  localparam int          WDOG_LIMIT = 20000;
  localparam int          SETTLE     = 100;
  localparam int          HOLD_LEN   = 400;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  hqn_in_t    in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  hqn_out_t   out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  heightfield_quad_normal_gen DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: mirror of the height store and the size registers
  // --------------------------------------------------------------------------
  logic signed [15:0] heights [0:SIDE*SIDE-1];
  bit                 written [0:SIDE*SIDE-1];
  logic [7:0]         width_reg  = 8'd128;
  logic [7:0]         length_reg = 8'd128;
  hqn_out_t           vertex_q [$];

  int  n_errors = 0;
  int  n_loads = 0, n_cells = 0, n_vertices = 0, n_items = 0;
  int  idle_cycles = 0;
  bit  quiet_mode = 1'b0;   // no gaps on either side while set, but a pending hold still applies
  bit  hold_req = 1'b0;

  function automatic int unsigned sat_side(logic [7:0] r);
    if (r < 2) return 2;
    if (r > SIDE) return SIDE;
    return r;
  endfunction

  function automatic int signed hval(int unsigned c, int unsigned r);
    return heights[r*SIDE + c];
  endfunction

  // round(|v| * 2^14 / sqrt(s)), exact, ties away from zero, sign of v
  function automatic logic [15:0] unit_comp(int signed v, longint unsigned s);
    longint unsigned mag, a, lim, lo, hi, mid, t;
    mag = (v < 0) ? -v : v;
    a   = mag * 16384;
    lim = 4 * a * a;
    lo  = 0;
    hi  = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t   = 2 * mid - 1;
      if (t * t * s <= lim) lo = mid;
      else hi = mid - 1;
    end
    return (v < 0) ? 16'(-lo) : 16'(lo);
  endfunction

  // Work out the vertex beats one accepted beat causes and queue them; a load beat only updates the mirror
  task automatic predict_beat(hqn_in_t b);
    int unsigned w, l, vx, vz;
    int signed   dx, dz;
    longint unsigned s;
    bit          border;
    hqn_out_t    v;
    int unsigned ox [4] = '{1, 0, 0, 1};
    int unsigned oz [4] = '{0, 0, 1, 1};
    if (b.mode == MODE_LOAD) begin
      heights[b.row*SIDE + b.col] = b.height;
      n_loads++;
      return;
    end
    w = sat_side(width_reg);
    l = sat_side(length_reg);
    if (b.col + 1 >= w || b.row + 1 >= l) return;
    n_cells++;
    border = (b.col == 0 || b.col == w - 2 || b.row == 0 || b.row == l - 2);
    for (int k = 0; k < 4; k++) begin
      vx = b.col + ox[k];
      vz = b.row + oz[k];
      v.pos_x = 8'(int'(vx) - int'(w / 2));
      v.pos_y = 16'(hval(vx, vz));
      v.pos_z = 8'(int'(vz) - int'(l / 2));
      if (border) begin
        v.norm_x = '0;
        v.norm_y = ONE_Q14;
        v.norm_z = '0;
      end else begin
        dx = hval(vx - 1, vz) - hval(vx + 1, vz);
        dz = hval(vx, vz - 1) - hval(vx, vz + 1);
        s  = longint'(dx) * dx + 65536 + longint'(dz) * dz;
        v.norm_x = unit_comp(dx, s);
        v.norm_y = 15'(unit_comp(int'(ONE_Q88), s));
        v.norm_z = unit_comp(dz, s);
      end
      v.last = (k == 3);
      vertex_q = {vertex_q, v};
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender: one beat per call, valid held high between back-to-back beats
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    if (quiet_mode) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    return $urandom_range(0, 2);
  endfunction

  task automatic send_beat(hqn_in_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat(b);
    n_items++;
  endtask

  task automatic load_sample(int unsigned c, int unsigned r, logic [15:0] h);
    hqn_in_t b;
    b.mode   = MODE_LOAD;
    b.col    = 7'(c);
    b.row    = 7'(r);
    b.height = h;
    written[r*SIDE + c] = 1'b1;
    send_beat(b);
  endtask

  // Ask for a cell; fill in any sample it would read that was never loaded
  task automatic gen_cell(int unsigned c, int unsigned r);
    hqn_in_t b;
    int unsigned w, l;
    int lo_c, lo_r, hi_c, hi_r;
    w = sat_side(width_reg);
    l = sat_side(length_reg);
    if (c + 1 < w && r + 1 < l) begin
      lo_c = (c > 0) ? c - 1 : 0;
      lo_r = (r > 0) ? r - 1 : 0;
      hi_c = (c + 2 < SIDE) ? c + 2 : SIDE - 1;
      hi_r = (r + 2 < SIDE) ? r + 2 : SIDE - 1;
      for (int rr = lo_r; rr <= hi_r; rr++)
        for (int cc = lo_c; cc <= hi_c; cc++)
          if (!written[rr*SIDE + cc]) load_sample(cc, rr, 16'($urandom));
    end
    b.mode   = MODE_GEN;
    b.col    = 7'(c);
    b.row    = 7'(r);
    b.height = 16'($urandom);
    send_beat(b);
  endtask

  // Drop valid and wait until every queued vertex has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic [7:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_WIDTH) width_reg = val;
    else if (idx == REG_LENGTH) length_reg = val;
  endtask

  task automatic set_grid(logic [7:0] w, logic [7:0] l);
    drain();
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_LENGTH, l);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, calm stretches, and a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int run;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
      end
      if (quiet_mode) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 49) == 0) begin
        run = $urandom_range(20, 80);
        out_stall <= 1'b1;
        repeat (run) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  // Compare each vertex beat with the oldest prediction
  always @(posedge clk) begin
    hqn_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (vertex_q.size() == 0) begin
        $error("vertex beat with nothing expected: %p", out_data);
        n_errors++;
      end else begin
        e = vertex_q.pop_front();
        n_vertices++;
        if (out_data.pos_x !== e.pos_x) begin
          $error("pos_x expected %0d got %0d", e.pos_x, out_data.pos_x); n_errors++;
        end
        if (out_data.pos_y !== e.pos_y) begin
          $error("pos_y expected %0d got %0d", e.pos_y, out_data.pos_y); n_errors++;
        end
        if (out_data.pos_z !== e.pos_z) begin
          $error("pos_z expected %0d got %0d", e.pos_z, out_data.pos_z); n_errors++;
        end
        if (out_data.norm_x !== e.norm_x) begin
          $error("norm_x expected %0d got %0d", e.norm_x, out_data.norm_x); n_errors++;
        end
        if (out_data.norm_y !== e.norm_y) begin
          $error("norm_y expected %0d got %0d", e.norm_y, out_data.norm_y); n_errors++;
        end
        if (out_data.norm_z !== e.norm_z) begin
          $error("norm_z expected %0d got %0d", e.norm_z, out_data.norm_z); n_errors++;
        end
        if (out_data.last !== e.last) begin
          $error("last expected %0b got %0b", e.last, out_data.last); n_errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no beat on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Full-size grid: corner samples, border cells, out-of-range cells, and
  // interior cells with a flat patch and with a checkerboard of extremes
  task automatic test_full_grid_extremes();
    load_sample(127, 127, 16'h7FFF);
    load_sample(0, 0, 16'h8000);
    gen_cell(0, 0);
    gen_cell(126, 126);
    gen_cell(127, 3);
    gen_cell(3, 127);
    for (int r = 9; r <= 12; r++)
      for (int c = 9; c <= 12; c++) load_sample(c, r, 16'h0155);
    gen_cell(10, 10);
    // checkerboard of extremes: samples two apart match, so every difference is zero
    for (int r = 19; r <= 22; r++)
      for (int c = 19; c <= 22; c++)
        load_sample(c, r, ((r + c) % 2) ? 16'h7FFF : 16'h8000);
    gen_cell(20, 20);
  endtask

  task automatic test_smallest_grid();
    set_grid(8'd2, 8'd2);
    gen_cell(0, 0);
    gen_cell(1, 0);
    gen_cell(0, 1);
  endtask

  // Register values outside 2..MAX_SIDE saturate; a spare index is ignored
  task automatic test_register_saturation();
    set_grid(8'd255, 8'd0);
    cfg_write(REG_SPARE, 8'hA5);
    gen_cell(126, 0);
    gen_cell(5, 1);
    set_grid(8'd1, 8'd129);
    cfg_write(REG_SPARE, 8'h5A);
    gen_cell(0, 126);
    gen_cell(0, 40);
  endtask

  task automatic test_random_cells(int unsigned w, int unsigned l, int n);
    hqn_in_t b;
    int unsigned p;
    set_grid(8'(w), 8'(l));
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 9);
      if (p < 6) begin
        gen_cell($urandom_range(0, w - 2), $urandom_range(0, l - 2));
      end else if (p < 8) begin
        load_sample($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
                    16'($urandom));
      end else begin
        // out-of-range cell: no beat back
        b = hqn_in_t'(31'($urandom));
        b.mode = MODE_GEN;
        b.col  = 7'($urandom_range(w - 1, SIDE - 1));
        send_beat(b);
      end
    end
  endtask

  // Hold the output for a long stretch while border cells keep coming
  task automatic test_backpressure();
    set_grid(8'd6, 8'd6);
    quiet_mode = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) gen_cell(i % 5, 0);
    quiet_mode = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_full_grid_extremes();
    test_smallest_grid();
    test_register_saturation();
    test_backpressure();
    test_random_cells(8'd5, 8'd7, 40);
    test_random_cells(8'd12, 8'd4, 40);
    test_random_cells(8'd128, 8'd128, 6);
    quiet_mode = 1'b1;
    test_random_cells(8'd9, 8'd9, 20);
    quiet_mode = 1'b0;
    while (n_items < 350) test_random_cells($urandom_range(3, 16), $urandom_range(3, 16), 30);
    drain();

    $display("Covered %0d beats in: %0d samples loaded, %0d cells generated,",
             n_items, n_loads, n_cells);
    $display("%0d vertices compared over grids from 2x2 to 128x128.", n_vertices);
    if (n_errors == 0 && vertex_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      if (vertex_q.size() != 0) $error("%0d vertices never arrived", vertex_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
